// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ATT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle, outside reset
`define ATT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== hw/rtl/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// types, constants and helpers for the accelerometer tilt angle block
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int ATT_CORDIC_STEPS = 16;
  localparam int ATT_MAX_STEPS    = 24;
  localparam int ATT_FRAC_BITS    = 14;

  // cordic datapath width: covers the gain growth of a 2^29.5 vector
  localparam int ATT_W   = 34;
  // angle accumulator width in 1/65536 degree
  localparam int ATT_Z_W = 25;

  // 1/K cordic gain in q30
  localparam logic [29:0] ATT_INV_GAIN = 30'd652032874;
  localparam int          ATT_ANGLE_LIMIT = 23040;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  localparam logic [23:0] ATT_ATAN [ATT_MAX_STEPS] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
    24'd58666,   24'd29335,   24'd14668,  24'd7334,   24'd3667,   24'd1833,
    24'd917,     24'd458,     24'd229,    24'd115,    24'd57,     24'd29,
    24'd14,      24'd7,       24'd4,      24'd2,      24'd1,      24'd0
  };

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } att_sample_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } att_result_t;

  function automatic int att_step_limit(input int steps);
    return (steps > ATT_MAX_STEPS) ? ATT_MAX_STEPS : steps;
  endfunction

  // cycles from an accepted start to its done strobe
  function automatic int att_latency(input int steps);
    return 2 * att_step_limit(steps) + 5;
  endfunction

endpackage

// ===== hw/rtl/accel_tilt_angles_top.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// roll and pitch in 1/256 degree from one raw three-axis accelerometer sample
// ----------------------------------------------------------------------------
// A sample is taken on every cycle that start is high; busy stays low, so a
// new sample may follow in the very next cycle. Each sample yields one
// result, shown on result for exactly one cycle with done high. Each angle
// passes through two N-stage CORDIC pipelines in series (N = CORDIC_STEPS,
// capped at 24), the gain multiplier and the round and clamp stages. The
// receiver cannot stall, so results must be captured when done is high.
module accel_tilt_angles_top
  import att_pkg::*;
#(
  parameter int CORDIC_STEPS = ATT_CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  att_sample_t sample,
  output logic        done,
  output att_result_t result
);

  localparam int STEP_LIMIT = att_step_limit(CORDIC_STEPS);
  localparam int LANE_LAT   = 2 * STEP_LIMIT + 4;

  logic [LANE_LAT-1:0] vpipe;
  logic signed [15:0]  roll_raw;
  logic signed [15:0]  pitch_raw;

  assign busy = 1'b0;

  att_cordic_lane #(.STEPS(STEP_LIMIT)) u_roll (
    .clk   (clk),
    .a     (sample.accel_x),
    .b     (sample.accel_z),
    .c     (sample.accel_y),
    .angle (roll_raw)
  );

  att_cordic_lane #(.STEPS(STEP_LIMIT)) u_pitch (
    .clk   (clk),
    .a     (sample.accel_y),
    .b     (sample.accel_z),
    .c     (sample.accel_x),
    .angle (pitch_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[LANE_LAT-2:0], start && !busy};
      done  <= vpipe[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    result.roll_angle  <= roll_raw;
    result.pitch_angle <= 16'sd0 - pitch_raw;
  end

endmodule

// ===== hw/rtl/att_cordic_lane.sv =====
// ----------------------------------------------------------------------------
// att_cordic_lane
// pipelined angle of (c, sqrt(a^2 + b^2)): cordic magnitude, gain fixup,
// cordic angle, round and clamp, one stage per step
// ----------------------------------------------------------------------------
module att_cordic_lane
  import att_pkg::*;
#(
  parameter int STEPS = ATT_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic signed [15:0] c,
  output logic signed [15:0] angle
);

  localparam int W  = ATT_W;
  localparam int ZW = ATT_Z_W;

  logic [16:0]         a_abs;
  logic signed [W-1:0] mx [0:STEPS];
  logic signed [W-1:0] my [0:STEPS];
  logic signed [15:0]  mc [0:STEPS+1];
  logic [60:0]         prod;
  logic [61:0]         prod_rnd;
  logic signed [W-1:0]  ax [0:STEPS];
  logic signed [W-1:0]  ay [0:STEPS];
  logic signed [ZW-1:0] az [0:STEPS];
  logic                 zf [1:STEPS];
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   r;
  logic signed [15:0]   angle_next;

  assign a_abs = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};

  always_ff @(posedge clk) begin
    mx[0] <= {3'b000, a_abs, 14'd0};
    my[0] <= {{4{b[15]}}, b, 14'd0};
    mc[0] <= c;
  end

  // magnitude pass
  for (genvar k = 0; k < STEPS; k++) begin : g_mag
    always_ff @(posedge clk) begin
      if (!my[k][W-1]) begin
        mx[k+1] <= mx[k] + (my[k] >>> k);
        my[k+1] <= my[k] - (mx[k] >>> k);
      end else begin
        mx[k+1] <= mx[k] - (my[k] >>> k);
        my[k+1] <= my[k] + (mx[k] >>> k);
      end
      mc[k+1] <= mc[k];
    end
  end

  // gain fixup: magnitude is positive and below 2^31
  assign prod_rnd = {1'b0, prod} + (62'd1 << 29);

  always_ff @(posedge clk) begin
    prod        <= 61'(mx[STEPS][30:0]) * 61'(ATT_INV_GAIN);
    mc[STEPS+1] <= mc[STEPS];
    ax[0]       <= {2'b00, prod_rnd[61:30]};
    ay[0]       <= {{4{mc[STEPS+1][15]}}, mc[STEPS+1], 14'd0};
    az[0]       <= '0;
  end

  // angle pass
  for (genvar k = 0; k < STEPS; k++) begin : g_ang
    always_ff @(posedge clk) begin
      if (!ay[k][W-1]) begin
        ax[k+1] <= ax[k] + (ay[k] >>> k);
        ay[k+1] <= ay[k] - (ax[k] >>> k);
        az[k+1] <= az[k] + $signed({1'b0, ATT_ATAN[k]});
      end else begin
        ax[k+1] <= ax[k] - (ay[k] >>> k);
        ay[k+1] <= ay[k] + (ax[k] >>> k);
        az[k+1] <= az[k] - $signed({1'b0, ATT_ATAN[k]});
      end
    end
    if (k == 0) begin : g_zf_first
      // zero vector gives zero angle, as atan2(0,0)
      always_ff @(posedge clk) begin
        zf[1] <= (ax[0] == '0) && (ay[0] == '0);
      end
    end else begin : g_zf_pass
      always_ff @(posedge clk) begin
        zf[k+1] <= zf[k];
      end
    end
  end

  always_comb begin
    z_rnd = az[STEPS] + ZW'(128);
    r     = z_rnd[ZW-1:8];
    if (zf[STEPS]) begin
      angle_next = '0;
    end else if (r > 17'(ATT_ANGLE_LIMIT)) begin
      angle_next = 16'(ATT_ANGLE_LIMIT);
    end else if (r < -17'(ATT_ANGLE_LIMIT)) begin
      angle_next = -16'(ATT_ANGLE_LIMIT);
    end else begin
      angle_next = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    angle <= angle_next;
  end

endmodule

// ===== hw/rtl/att_checker.sv =====
// ----------------------------------------------------------------------------
// att_port_checks
// port level checks for the tilt angle block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module att_port_checks
  import att_pkg::*;
#(
  parameter int CORDIC_STEPS = ATT_CORDIC_STEPS
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input att_sample_t sample,
  input logic        done,
  input att_result_t result
);

  localparam int LAT = att_latency(CORDIC_STEPS);

  `ATT_ASSERT(a_never_busy, clk, rst, !busy)

  // every done strobe traces back to a transaction a fixed latency earlier
  `ATT_ASSERT_IMPL(a_done_has_start, clk, rst, done, $past(start, LAT))

  `ATT_ASSERT_IMPL(a_roll_range, clk, rst, done,
    (result.roll_angle <= 16'sd23040) && (result.roll_angle >= -16'sd23040))

  // all-zero sample gives zero angles
  `ATT_ASSERT_IMPL(a_zero_sample, clk, rst, done && ($past(sample, LAT) == '0),
    result == '0)

endmodule

bind accel_tilt_angles_top att_port_checks #(.CORDIC_STEPS(CORDIC_STEPS)) u_att_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .sample (sample),
  .done   (done),
  .result (result)
);
